// File: rtl/core/sha_pkg.sv
// Package for the SHA-256 engine: constants, types and round functions.
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned LenW    = 61;
  localparam int unsigned Rounds  = 64;

  typedef logic [WordW-1:0] word_t;

  // Round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Initial hash values
  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// File: rtl/core/sha_if.sv
// Handshake channel interfaces for the SHA-256 engine.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/sha256_hash_engine.sv
// SHA-256 engine top level: byte packing, padding sequencer and round unit.
// Bytes are packed one per cycle, except while a full block is compressed; ready stays low
// until the accepted word is packed, so no new word is taken before the last one is done.
// A full block runs 64 rounds on one shared round unit, plus the chain update; end of
// message adds zero fill (one byte per cycle), one or two blocks, then 8 words.
// Reset: asynchronous active low; chain hash to initial values, length zero.
module sha256_hash_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha_in_if.sink       in_i,
  sha_out_if.source    out_o
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StByte  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]      state_q, state_d;
  word_t           hash_q [8];
  word_t           vars_q [8];
  word_t           sched_q [16];
  word_t           buf_q [16];  // block buffer, four bytes per entry, first byte on top
  logic [LenW-1:0] len_q;
  logic [31:0]     word_q;
  logic [2:0]      cnt_q;
  logic            fin_q;
  logic [5:0]      rnd_q;
  logic [5:0]      pad_pos_q;
  logic            pad_q;    // compressing during padding
  logic            last_blk_q;
  logic [2:0]      oidx_q;
  logic [63:0]     bits_q;

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = (state_q == StOut);
  assign out_o.digest_word = hash_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 3'd7);

  // Round datapath
  word_t w_cur, s0, s1, t1, t2, w2, w15;
  always_comb begin
    w2  = sched_q[4'(rnd_q - 6'd2)];
    w15 = sched_q[4'(rnd_q - 6'd15)];
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    if (rnd_q < 6'd16) begin
      w_cur = buf_q[rnd_q[3:0]];
    end else begin
      w_cur = s1 + sched_q[4'(rnd_q - 6'd7)] + s0 + sched_q[rnd_q[3:0]];
    end
    t1 = vars_q[7] + (rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25))
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) + round_k(rnd_q) + w_cur;
    t2 = (rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22))
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
  end

  logic [2:0] eff_cnt;
  assign eff_cnt = (in_i.valid_bytes > 3'd4) ? 3'd4 : in_i.valid_bytes;

  logic [5:0] pos;
  assign pos = len_q[5:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_i.valid) state_d = StByte;
      StByte, StRound, StAdd, StPad: state_d = state_q;
      StOut:   state_d = state_q;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      pad_q   <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            word_q  <= in_i.message_word;
            cnt_q   <= eff_cnt;
            fin_q   <= in_i.end_of_message;
            state_q <= state_d;
          end
        end
        StByte: begin
          if (cnt_q != 3'd0) begin
            buf_q[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= word_q[31:24];
            word_q     <= {word_q[23:0], 8'h00};
            cnt_q      <= cnt_q - 3'd1;
            len_q      <= len_q + 1'b1;
            if (pos == 6'd63) begin
              pad_q   <= 1'b0;
              rnd_q   <= '0;
              for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
              state_q <= StRound;
            end
          end else if (fin_q) begin
            bits_q     <= {len_q, 3'b000};
            buf_q[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= 8'h80;
            pad_pos_q  <= pos + 6'd1;
            last_blk_q <= (pos < 6'd56);
            if (pos == 6'd63) begin
              // marker ends the block: compress it, length goes in a second block
              pad_q   <= 1'b1;
              rnd_q   <= '0;
              for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
              state_q <= StRound;
            end else begin
              state_q <= StPad;
            end
          end else begin
            state_q <= StIdle;
          end
        end
        StPad: begin
          // zero fill, then the 64-bit bit length in the last block
          if (last_blk_q && pad_pos_q == 6'd56) begin
            buf_q[4'd14] <= bits_q[63:32];
            buf_q[4'd15] <= bits_q[31:0];
            pad_q   <= 1'b1;
            rnd_q   <= '0;
            for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
            state_q <= StRound;
          end else begin
            buf_q[pad_pos_q[5:2]][{~pad_pos_q[1:0], 3'b000} +: 8] <= 8'h00;
            pad_pos_q <= pad_pos_q + 6'd1;
            if (pad_pos_q == 6'd63) begin
              pad_q   <= 1'b1;
              rnd_q   <= '0;
              for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          if (rnd_q >= 6'd16) sched_q[rnd_q[3:0]] <= w_cur;
          else sched_q[rnd_q[3:0]] <= w_cur;
          vars_q[7] <= vars_q[6]; vars_q[6] <= vars_q[5]; vars_q[5] <= vars_q[4];
          vars_q[4] <= vars_q[3] + t1;
          vars_q[3] <= vars_q[2]; vars_q[2] <= vars_q[1]; vars_q[1] <= vars_q[0];
          vars_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'(Rounds - 1)) state_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[i];
          if (!pad_q) begin
            state_q <= StByte;
          end else if (last_blk_q) begin
            oidx_q  <= '0;
            state_q <= StOut;
          end else begin
            // second padding block: zeros then length
            last_blk_q <= 1'b1;
            pad_pos_q  <= '0;
            state_q    <= StPad;
          end
        end
        StOut: begin
          if (out_o.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
              len_q   <= '0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("ready while emitting");
  a_out_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> (len_q == '0))
    else $error("length not restarted");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == 6'd63) |=> (state_q == StAdd))
    else $error("round count");
`endif
endmodule

// File: test/sha256_hash_engine_tb.sv
// Testbench for the SHA-256 engine: directed and random messages checked against a local predictor.
`timescale 1ns / 100ps

class digest_board;
  logic [31:0] chain_h [8];
  logic [7:0]  blk [64];
  logic [60:0] byte_cnt;
  logic [31:0] exp_word [$];
  logic [2:0]  exp_idx [$];
  logic        exp_last [$];
  int          n_errors;
  int          n_digests;

  function new();
    restart();
    n_errors = 0;
    n_digests = 0;
    foreach (blk[i]) blk[i] = 8'h00;
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain_h[i] = sha_pkg::init_h(3'(i));
    byte_cnt = '0;
  endfunction

  static function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wt = w[i];
      end else begin
        s1 = ror(w[(i-2)&15], 17) ^ ror(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
        s0 = ror(w[(i-15)&15], 7) ^ ror(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
        wt = s1 + w[(i-7)&15] + s0 + w[i&15];
        w[i&15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(6'(i)) + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endfunction

  function void add_byte(logic [7:0] b);
    int pos;
    pos = int'(byte_cnt[5:0]);
    blk[pos] = b;
    byte_cnt = byte_cnt + 1'b1;
    if (pos == 63) compress();
  endfunction

  // note one accepted input word
  function void note_word(logic [31:0] data, logic [2:0] nbytes, logic eom);
    int cnt, pos;
    logic [63:0] bits;
    cnt = (nbytes > 3'd4) ? 4 : int'(nbytes);
    for (int i = 0; i < cnt; i++) add_byte(data[31-8*i -: 8]);
    if (!eom) return;
    bits = {byte_cnt, 3'b000};
    pos = int'(byte_cnt[5:0]);
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) blk[i] = 8'h00;
      compress();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(chain_h[i]);
      exp_idx.push_back(3'(i));
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  task report(string msg);
    $display("MISMATCH %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // check one accepted digest word
  task check_word(logic [31:0] dw, logic [2:0] idx, logic last);
    if (exp_word.size() == 0) begin
      report($sformatf("unexpected digest word %h", dw));
      return;
    end
    if (dw !== exp_word[0])
      report($sformatf("digest_word %h, want %h", dw, exp_word[0]));
    if (idx !== exp_idx[0])
      report($sformatf("word_index %0d, want %0d", idx, exp_idx[0]));
    if (last !== exp_last[0])
      report($sformatf("last_word %b, want %b", last, exp_last[0]));
    if (last === 1'b1 && exp_last[0]) n_digests++;
    void'(exp_word.pop_front());
    void'(exp_idx.pop_front());
    void'(exp_last.pop_front());
  endtask
endclass

module sha256_hash_engine_tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   n_sent = 0;
  int   gap_left = 0;
  bit   stall_on = 0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_hash_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  digest_board board = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.message_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver: stalls in runs, sometimes a long stretch of none
  always @(negedge clk_i) begin
    if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
    out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
  end

  // send one word, with a random gap between bursts
  task automatic send_word(logic [31:0] data, logic [2:0] nbytes, logic eom);
    if (gap_left == 0 && $urandom_range(0, 7) == 0)
      gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      gap_left--;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.message_word <= data;
    in_ch.valid_bytes <= nbytes;
    in_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_word(data, nbytes, eom);
    n_sent++;
  endtask

  // one well-formed message of nwords full words plus a random tail
  task automatic send_message(int nwords);
    for (int i = 0; i < nwords; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty message, extremes, oversized counts, empty items
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'h12345678, 3'd0, 1'b0);
    send_word(32'h00000000, 3'd7, 1'b0);
    send_word(32'hdeadbeef, 3'd5, 1'b0);
    send_word(32'hffffffff, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b0);
    send_word(32'h00000000, 3'd2, 1'b1);
    // padding on the boundary: 55 bytes, then 52 or 64 bytes plus a random tail
    for (int i = 0; i < 13; i++) send_word(32'haaaaaaaa, 3'd4, 1'b0);
    send_word(32'h55555555, 3'd3, 1'b1);
    send_message(13);
    send_message(16);
    // random: mostly messages, some noise items
    while (n_sent < 520) begin
      if ($urandom_range(0, 9) == 0)
        send_word($urandom, 3'd0, 1'b0);
      else
        send_message(($urandom_range(0, 3) == 0) ? $urandom_range(10, 33)
                                                 : $urandom_range(0, 6));
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.exp_word.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words, %0d digests checked, including boundary padding",
             n_sent, board.n_digests);
    if (board.n_errors == 0) begin
      $display("sha256_hash_engine_tb: clean");
    end else begin
      $display("sha256_hash_engine_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("sha256_hash_engine_tb: errors");
    $finish;
  end
endmodule
